// File: rtl/core/pfpd_pkg.sv
// Package for the plane-from-points distance block: widths and action codes.
// No dependencies; used by the interfaces and all modules.
package pfpd_pkg;

    localparam int COORD_W   = 24;   // Q8.16 coordinates and distance
    localparam int NORMAL_W  = 32;   // Q1.30 normal components
    localparam int NORM_FRAC = 30;
    localparam int OFFSET_W  = COORD_W + 2;
    localparam int RAW_W     = 2 * COORD_W + 3;  // cross product components
    localparam int MUL_W     = 33;               // shared multiplier operand width
    localparam int ACC_W     = 2 * MUL_W;        // product and accumulator width
    localparam int RAD_W     = 64;               // square-root radicand, dividend
    localparam int ROOT_W    = 32;               // root, divisor, quotient

    localparam logic [1:0] ACT_POINTS = 2'd0;
    localparam logic [1:0] ACT_NORMAL = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;   // no operation, plain result word

endpackage

// File: rtl/core/pfpd_if.sv
// Valid/ready channel interfaces for input and result words.
// Depends on pfpd_pkg.
interface pfpd_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          action;
    logic signed [pfpd_pkg::COORD_W-1:0] x_first;
    logic signed [pfpd_pkg::COORD_W-1:0] y_first;
    logic signed [pfpd_pkg::COORD_W-1:0] z_first;
    logic signed [pfpd_pkg::COORD_W-1:0] x_second;
    logic signed [pfpd_pkg::COORD_W-1:0] y_second;
    logic signed [pfpd_pkg::COORD_W-1:0] z_second;
    logic signed [pfpd_pkg::COORD_W-1:0] x_third;
    logic signed [pfpd_pkg::COORD_W-1:0] y_third;
    logic signed [pfpd_pkg::COORD_W-1:0] z_third;
    logic                                signed_mode;

    modport source (output valid, action, x_first, y_first, z_first, x_second, y_second,
                    z_second, x_third, y_third, z_third, signed_mode, input ready);
    modport sink   (input valid, action, x_first, y_first, z_first, x_second, y_second,
                    z_second, x_third, y_third, z_third, signed_mode, output ready);
endinterface

interface pfpd_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pfpd_pkg::COORD_W-1:0]  distance;
    logic signed [pfpd_pkg::NORMAL_W-1:0] normal_x;
    logic signed [pfpd_pkg::NORMAL_W-1:0] normal_y;
    logic signed [pfpd_pkg::NORMAL_W-1:0] normal_z;
    logic signed [pfpd_pkg::OFFSET_W-1:0] offset;
    logic                                 degenerate;

    modport source (output valid, distance, normal_x, normal_y, normal_z, offset,
                    degenerate, input ready);
    modport sink   (input valid, distance, normal_x, normal_y, normal_z, offset,
                    degenerate, output ready);
endinterface

// File: rtl/core/pfpd_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on pfpd_pkg.
module pfpd_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pfpd_pkg::RAD_W-1:0]    i_radicand,
    output logic                          o_done,
    output logic [pfpd_pkg::ROOT_W-1:0]   o_root
);
    logic [pfpd_pkg::RAD_W-1:0] r_x;
    logic [pfpd_pkg::RAD_W-1:0] r_res;
    logic [pfpd_pkg::RAD_W-1:0] r_bit;
    logic [4:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [pfpd_pkg::RAD_W-1:0] w_trial;

    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_radicand;
                r_res  <= '0;
                r_bit  <= {2'b01, {(pfpd_pkg::RAD_W-2){1'b0}}};
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_x >= w_trial) begin
                    r_x   <= r_x - w_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[pfpd_pkg::ROOT_W-1:0];
endmodule

// File: rtl/core/pfpd_div.sv
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
// Caller guarantees the upper dividend half is below the divisor. Depends on pfpd_pkg.
module pfpd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pfpd_pkg::RAD_W-1:0]    i_dividend,
    input  logic [pfpd_pkg::ROOT_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [pfpd_pkg::ROOT_W-1:0]   o_quot
);
    logic [pfpd_pkg::ROOT_W-1:0] r_rem;
    logic [pfpd_pkg::ROOT_W-1:0] r_q;
    logic [pfpd_pkg::ROOT_W-1:0] r_dvs;
    logic [4:0]                  r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [pfpd_pkg::ROOT_W:0]   w_t;
    logic [pfpd_pkg::ROOT_W:0]   w_sub;
    logic                        w_ge;

    assign w_t   = {r_rem, r_q[pfpd_pkg::ROOT_W-1]};
    assign w_ge  = (w_t >= {1'b0, r_dvs});
    assign w_sub = w_t - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_dividend[pfpd_pkg::RAD_W-1:pfpd_pkg::ROOT_W];
                r_q    <= i_dividend[pfpd_pkg::ROOT_W-1:0];
                r_dvs  <= i_divisor;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[pfpd_pkg::ROOT_W-1:0] : w_t[pfpd_pkg::ROOT_W-1:0];
                r_q   <= {r_q[pfpd_pkg::ROOT_W-2:0], w_ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// File: rtl/core/plane_from_points_distance.sv
// Plane from points / point-to-plane distance, top level.
// Depends on pfpd_pkg, pfpd_if, pfpd_isqrt, pfpd_div.
//
// Holds one plane n.p + d = 0 (unit normal Q1.30, offset Q10.16), z = 0 after
// reset. Action 0 builds the plane through three points, action 1 from a
// normal and a point; a zero normal flags degenerate and keeps the old plane.
// Action 2 returns the (optionally absolute) distance of a point, saturated.
// Every input word yields one result word carrying the current plane. One
// word is in flight at a time: ready is high only while the sequencer idles.
// A query takes the sum of squares through the shared 33x33 multiplier, a
// 32-step square root, the dot product and a 32-step divide. A build (normal
// and point, or three points with six cross-product multiplies) shifts the
// raw normal one bit at a time to normalize it (up to 30 bits), then runs
// the square root and three 32-step divides. The square root and the divider
// each retire one result bit per cycle. A finished result sits in an output
// register, so the next word is accepted while the previous result waits.
module plane_from_points_distance (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfpd_in_if.sink    i_in,
    pfpd_out_if.source o_out
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_CHK, S_NORM, S_SQRT, S_QSET, S_DIV, S_FIN
    } t_state;

    // which product sequence the multiplier runs
    typedef enum logic [2:0] {
        M_CROSS, M_MSQ, M_PDOT, M_NSQ, M_QDOT
    } t_mode;

    localparam int CW = pfpd_pkg::COORD_W;
    localparam int NW = pfpd_pkg::NORMAL_W;
    localparam int OW = pfpd_pkg::OFFSET_W;
    localparam int RW = pfpd_pkg::RAW_W;
    localparam int AW = pfpd_pkg::ACC_W;
    localparam int QW = pfpd_pkg::ROOT_W;
    localparam int FB = pfpd_pkg::NORM_FRAC;

    t_state r_state;
    t_mode  r_mode;
    logic [2:0] r_k;
    logic       r_ph;

    logic [1:0]           r_act;
    logic                 r_smode;
    logic signed [CW-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz, r_cx, r_cy, r_cz;

    logic signed [RW-1:0] r_rx, r_ry, r_rz;       // raw normal
    logic [RW-1:0]        r_m0, r_m1, r_m2;       // magnitudes being normalized
    logic                 r_n0, r_n1, r_n2;       // raw normal signs
    logic signed [NW-1:0] r_qx, r_qy, r_qz;       // new unit normal
    logic [QW-1:0]        r_norm;

    logic signed [AW-1:0] r_prod, r_acc;

    // plane state
    logic signed [NW-1:0] r_pnx, r_pny, r_pnz;
    logic signed [OW-1:0] r_poff;

    logic signed [CW-1:0] r_dist;
    logic                 r_degen;

    // output register
    logic                 r_ov;
    logic signed [CW-1:0] r_o_dist;
    logic signed [NW-1:0] r_o_nx, r_o_ny, r_o_nz;
    logic signed [OW-1:0] r_o_off;
    logic                 r_o_degen;

    logic                   r_sq_start, r_dv_start;
    logic [pfpd_pkg::RAD_W-1:0] r_dvd;
    logic                   w_sq_done, w_dv_done;
    logic [QW-1:0]          w_root, w_quot;

    pfpd_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sq_start),
        .i_radicand (r_acc[pfpd_pkg::RAD_W-1:0]),
        .o_done     (w_sq_done),
        .o_root     (w_root)
    );

    pfpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dv_start),
        .i_dividend (r_dvd),
        .i_divisor  (r_norm),
        .o_done     (w_dv_done),
        .o_quot     (w_quot)
    );

    // edges for the cross product
    logic signed [CW:0] w_e1x, w_e1y, w_e1z, w_e2x, w_e2y, w_e2z;
    assign w_e1x = (CW+1)'(r_bx) - (CW+1)'(r_ax);
    assign w_e1y = (CW+1)'(r_by) - (CW+1)'(r_ay);
    assign w_e1z = (CW+1)'(r_bz) - (CW+1)'(r_az);
    assign w_e2x = (CW+1)'(r_cx) - (CW+1)'(r_ax);
    assign w_e2y = (CW+1)'(r_cy) - (CW+1)'(r_ay);
    assign w_e2z = (CW+1)'(r_cz) - (CW+1)'(r_az);

    // operand select for the shared multiplier
    logic signed [pfpd_pkg::MUL_W-1:0] w_opa, w_opb;
    logic signed [CW-1:0]              w_pt;
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        w_pt  = '0;
        case (r_mode)
            M_CROSS: begin
                case (r_k)
                    3'd0: begin w_opa = 33'(w_e1y); w_opb = 33'(w_e2z); end
                    3'd1: begin w_opa = 33'(w_e1z); w_opb = 33'(w_e2y); end
                    3'd2: begin w_opa = 33'(w_e1z); w_opb = 33'(w_e2x); end
                    3'd3: begin w_opa = 33'(w_e1x); w_opb = 33'(w_e2z); end
                    3'd4: begin w_opa = 33'(w_e1x); w_opb = 33'(w_e2y); end
                    default: begin w_opa = 33'(w_e1y); w_opb = 33'(w_e2x); end
                endcase
            end
            M_MSQ: begin
                case (r_k)
                    3'd0: w_opa = $signed({2'b00, r_m0[30:0]});
                    3'd1: w_opa = $signed({2'b00, r_m1[30:0]});
                    default: w_opa = $signed({2'b00, r_m2[30:0]});
                endcase
                w_opb = w_opa;
            end
            M_PDOT: begin
                case (r_k)
                    3'd0: begin
                        w_opa = 33'(r_qx);
                        w_pt  = (r_act == pfpd_pkg::ACT_POINTS) ? r_ax : r_bx;
                    end
                    3'd1: begin
                        w_opa = 33'(r_qy);
                        w_pt  = (r_act == pfpd_pkg::ACT_POINTS) ? r_ay : r_by;
                    end
                    default: begin
                        w_opa = 33'(r_qz);
                        w_pt  = (r_act == pfpd_pkg::ACT_POINTS) ? r_az : r_bz;
                    end
                endcase
                w_opb = 33'(w_pt);
            end
            M_NSQ: begin
                case (r_k)
                    3'd0: w_opa = 33'(r_pnx);
                    3'd1: w_opa = 33'(r_pny);
                    default: w_opa = 33'(r_pnz);
                endcase
                w_opb = w_opa;
            end
            default: begin
                case (r_k)
                    3'd0: begin w_opa = 33'(r_pnx); w_opb = 33'(r_ax); end
                    3'd1: begin w_opa = 33'(r_pny); w_opb = 33'(r_ay); end
                    default: begin w_opa = 33'(r_pnz); w_opb = 33'(r_az); end
                endcase
            end
        endcase
    end

    logic signed [AW-1:0] w_sum, w_diff;
    assign w_sum  = r_acc + r_prod;
    assign w_diff = r_acc - r_prod;
    logic w_last;
    assign w_last = (r_mode == M_CROSS) ? (r_k == 3'd5) : (r_k == 3'd2);

    // offset = sat(-round(dot >> 30)), dot taken from the final accumulate
    logic [AW-1:0]        w_dmag;
    logic [AW-FB-1:0]     w_omag;
    logic signed [OW-1:0] w_off;
    always_comb begin
        w_dmag = w_sum[AW-1] ? AW'(-w_sum) : AW'(w_sum);
        w_omag = (AW-FB)'((w_dmag + (AW'(1) << (FB-1))) >> FB);
        if (w_sum[AW-1]) begin
            w_off = (w_omag > (AW-FB)'((1 << (OW-1)) - 1)) ? OW'((1 << (OW-1)) - 1)
                                                             : OW'(w_omag);
        end else begin
            w_off = (w_omag > (AW-FB)'(1 << (OW-1))) ? OW'(-(1 << (OW-1)))
                                                       : OW'(-$signed({1'b0, w_omag}));
        end
    end

    // normalizing dividend: (m << 30) + norm/2
    function automatic logic [pfpd_pkg::RAD_W-1:0] build_dvd(
        input logic [RW-1:0] m, input logic [QW-1:0] nrm);
        build_dvd = {3'b000, m[30:0], {FB{1'b0}}} + {33'b0, nrm[QW-1:1]};
    endfunction

    // query numerator
    logic signed [AW-1:0] w_num;
    logic [AW-1:0]        w_nmag;
    assign w_num  = r_acc + (AW'(r_poff) <<< FB);
    assign w_nmag = w_num[AW-1] ? AW'(-w_num) : AW'(w_num);

    // saturated query distance
    logic [CW:0]          w_qc;
    logic signed [CW-1:0] w_qdist;
    always_comb begin
        w_qc = (w_quot > QW'(1 << (CW-1))) ? (CW+1)'(1 << (CW-1)) : (CW+1)'(w_quot);
        if (r_smode && w_num[AW-1]) begin
            w_qdist = CW'(-$signed(w_qc));
        end else if (w_qc == (CW+1)'(1 << (CW-1))) begin
            w_qdist = CW'((1 << (CW-1)) - 1);
        end else begin
            w_qdist = CW'(w_qc);
        end
    end

    logic [RW-1:0] w_mor;
    assign w_mor = r_m0 | r_m1 | r_m2;

    logic signed [NW-1:0] w_nq;
    always_comb begin
        case (r_k)
            3'd0: w_nq = r_n0 ? -$signed(w_quot) : $signed(w_quot);
            3'd1: w_nq = r_n1 ? -$signed(w_quot) : $signed(w_quot);
            default: w_nq = r_n2 ? -$signed(w_quot) : $signed(w_quot);
        endcase
    end

    // start pulses for the root and divide units
    logic w_sq_go, w_dv_go;
    assign w_sq_go = (r_state == S_MUL) && r_ph && w_last &&
                     (r_mode == M_MSQ || r_mode == M_NSQ);
    assign w_dv_go = ((r_state == S_SQRT) && w_sq_done && (r_mode != M_NSQ) &&
                      (w_root != '0)) ||
                     ((r_state == S_QSET) && (r_norm != '0)) ||
                     ((r_state == S_DIV) && w_dv_done &&
                      (r_act != pfpd_pkg::ACT_QUERY) && (r_k != 3'd2));

    assign i_in.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= M_CROSS;
            r_k        <= '0;
            r_ph       <= 1'b0;
            r_sq_start <= 1'b0;
            r_dv_start <= 1'b0;
            r_ov       <= 1'b0;
            r_pnx      <= '0;
            r_pny      <= '0;
            r_pnz      <= NW'(1 << FB);
            r_poff     <= '0;
        end else begin
            r_sq_start <= w_sq_go;
            r_dv_start <= w_dv_go;
            if (r_state == S_FIN && (!r_ov || o_out.ready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && o_out.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_act   <= i_in.action;
                        r_smode <= i_in.signed_mode;
                        r_ax <= i_in.x_first;  r_ay <= i_in.y_first;  r_az <= i_in.z_first;
                        r_bx <= i_in.x_second; r_by <= i_in.y_second; r_bz <= i_in.z_second;
                        r_cx <= i_in.x_third;  r_cy <= i_in.y_third;  r_cz <= i_in.z_third;
                        r_degen <= 1'b0;
                        r_dist  <= '0;
                        r_k     <= '0;
                        r_ph    <= 1'b0;
                        r_acc   <= '0;
                        case (i_in.action)
                            pfpd_pkg::ACT_POINTS: begin
                                r_mode  <= M_CROSS;
                                r_state <= S_MUL;
                            end
                            pfpd_pkg::ACT_NORMAL: begin
                                r_rx    <= RW'(i_in.x_first);
                                r_ry    <= RW'(i_in.y_first);
                                r_rz    <= RW'(i_in.z_first);
                                r_state <= S_CHK;
                            end
                            pfpd_pkg::ACT_QUERY: begin
                                r_mode  <= M_NSQ;
                                r_state <= S_MUL;
                            end
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_MUL: begin
                    if (!r_ph) begin
                        r_prod <= w_opa * w_opb;
                        r_ph   <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        if (r_mode == M_CROSS) begin
                            if (!r_k[0]) begin
                                r_acc <= r_prod;
                            end else begin
                                case (r_k[2:1])
                                    2'd0: r_rx <= w_diff[RW-1:0];
                                    2'd1: r_ry <= w_diff[RW-1:0];
                                    default: r_rz <= w_diff[RW-1:0];
                                endcase
                            end
                        end else begin
                            r_acc <= w_sum;
                        end
                        if (!w_last) begin
                            r_k <= r_k + 3'd1;
                        end else begin
                            r_k <= '0;
                            case (r_mode)
                                M_CROSS: r_state <= S_CHK;
                                M_MSQ, M_NSQ: r_state <= S_SQRT;
                                M_PDOT: begin
                                    r_pnx   <= r_qx;
                                    r_pny   <= r_qy;
                                    r_pnz   <= r_qz;
                                    r_poff  <= w_off;
                                    r_state <= S_FIN;
                                end
                                default: r_state <= S_QSET;
                            endcase
                        end
                    end
                end
                S_CHK: begin
                    if (r_rx == '0 && r_ry == '0 && r_rz == '0) begin
                        r_degen <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_m0 <= r_rx[RW-1] ? RW'(-r_rx) : RW'(r_rx);
                        r_m1 <= r_ry[RW-1] ? RW'(-r_ry) : RW'(r_ry);
                        r_m2 <= r_rz[RW-1] ? RW'(-r_rz) : RW'(r_rz);
                        r_n0 <= r_rx[RW-1];
                        r_n1 <= r_ry[RW-1];
                        r_n2 <= r_rz[RW-1];
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    // bring the largest magnitude into [2^30, 2^31)
                    if (|w_mor[RW-1:31]) begin
                        r_m0 <= r_m0 >> 1;
                        r_m1 <= r_m1 >> 1;
                        r_m2 <= r_m2 >> 1;
                    end else if (!w_mor[30]) begin
                        r_m0 <= r_m0 << 1;
                        r_m1 <= r_m1 << 1;
                        r_m2 <= r_m2 << 1;
                    end else begin
                        r_mode  <= M_MSQ;
                        r_k     <= '0;
                        r_ph    <= 1'b0;
                        r_acc   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_SQRT: begin
                    if (w_sq_done) begin
                        r_norm <= w_root;
                        r_k    <= '0;
                        r_ph   <= 1'b0;
                        if (r_mode == M_NSQ) begin
                            r_acc   <= '0;
                            r_mode  <= M_QDOT;
                            r_state <= S_MUL;
                        end else if (w_root == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_dvd   <= build_dvd(r_m0, w_root);
                            r_state <= S_DIV;
                        end
                    end
                end
                S_QSET: begin
                    if (r_norm == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_dvd   <= w_nmag[pfpd_pkg::RAD_W-1:0] + {33'b0, r_norm[QW-1:1]};
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_dv_done) begin
                        if (r_act == pfpd_pkg::ACT_QUERY) begin
                            r_dist  <= w_qdist;
                            r_state <= S_FIN;
                        end else begin
                            case (r_k)
                                3'd0: r_qx <= w_nq;
                                3'd1: r_qy <= w_nq;
                                default: r_qz <= w_nq;
                            endcase
                            if (r_k == 3'd2) begin
                                r_k     <= '0;
                                r_ph    <= 1'b0;
                                r_acc   <= '0;
                                r_mode  <= M_PDOT;
                                r_state <= S_MUL;
                            end else begin
                                r_k   <= r_k + 3'd1;
                                r_dvd <= build_dvd((r_k == 3'd0) ? r_m1 : r_m2, r_norm);
                            end
                        end
                    end
                end
                S_FIN: begin
                    if (!r_ov || o_out.ready) begin
                        r_o_dist  <= r_dist;
                        r_o_nx    <= r_pnx;
                        r_o_ny    <= r_pny;
                        r_o_nz    <= r_pnz;
                        r_o_off   <= r_poff;
                        r_o_degen <= r_degen;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.distance   = r_o_dist;
    assign o_out.normal_x   = r_o_nx;
    assign o_out.normal_y   = r_o_ny;
    assign o_out.normal_z   = r_o_nz;
    assign o_out.offset     = r_o_off;
    assign o_out.degenerate = r_o_degen;
endmodule

// File: sim/tb_plane_from_points_distance.sv
// Testbench for plane_from_points_distance: random and directed plane builds
// and distance queries, checked word by word against a behavioral predictor.
// Depends on pfpd_pkg, pfpd_if and the block's RTL.
module tb_plane_from_points_distance;

    typedef struct {
        logic [1:0]                          action;
        logic signed [pfpd_pkg::COORD_W-1:0] first  [3];
        logic signed [pfpd_pkg::COORD_W-1:0] second [3];
        logic signed [pfpd_pkg::COORD_W-1:0] third  [3];
        logic                                signed_mode;
    } t_plane_cmd;

    typedef struct packed {
        logic signed [pfpd_pkg::COORD_W-1:0]  distance;
        logic signed [pfpd_pkg::NORMAL_W-1:0] nx;
        logic signed [pfpd_pkg::NORMAL_W-1:0] ny;
        logic signed [pfpd_pkg::NORMAL_W-1:0] nz;
        logic signed [pfpd_pkg::OFFSET_W-1:0] offset;
        logic                                 degenerate;
    } t_plane_word;

    // Plane predictor plus queue of pending result words.
    class plane_scoreboard;
        longint      nrm [3];
        longint      ofs;
        t_plane_word pending [$];
        int          errors;

        function new();
            nrm[0] = 0;
            nrm[1] = 0;
            nrm[2] = longint'(1) << pfpd_pkg::NORM_FRAC;
            ofs = 0;
            errors = 0;
        endfunction

        static function longint shr_away(longint v, int s);
            longint m;
            m = (v < 0) ? -v : v;
            m = (m + (longint'(1) << (s - 1))) >>> s;
            return (v < 0) ? -m : m;
        endfunction

        static function longint unsigned root64(longint unsigned x);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv >>= 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        // Normalize raw normal r and put the plane through p.
        function void fit_plane(longint r [3], longint p [3]);
            longint unsigned m [3];
            longint unsigned mx, sum, root, q;
            longint n [3];
            longint dot, d, lim;
            int len;
            mx = 0;
            sum = 0;
            len = 0;
            for (int i = 0; i < 3; i++) begin
                m[i] = (r[i] < 0) ? -r[i] : r[i];
                if (m[i] > mx) mx = m[i];
            end
            while (len < 64 && (mx >> len) != 0) len++;
            for (int i = 0; i < 3; i++) begin
                if (len > 31) m[i] = m[i] >> (len - 31);
                else          m[i] = m[i] << (31 - len);
                sum += m[i] * m[i];
            end
            root = root64(sum);
            if (root == 0) return;
            for (int i = 0; i < 3; i++) begin
                q = ((m[i] << pfpd_pkg::NORM_FRAC) + root / 2) / root;
                n[i] = (r[i] < 0) ? -longint'(q) : longint'(q);
            end
            dot = n[0] * p[0] + n[1] * p[1] + n[2] * p[2];
            d = -shr_away(dot, pfpd_pkg::NORM_FRAC);
            lim = (longint'(1) << (pfpd_pkg::OFFSET_W - 1)) - 1;
            if (d > lim) d = lim;
            if (d < -lim - 1) d = -lim - 1;
            nrm = n;
            ofs = d;
        endfunction

        function void note_cmd(t_plane_cmd c);
            t_plane_word w;
            longint a [3], b [3], e [3], f [3], r [3];
            longint unsigned sum, den, q;
            longint dot, num;
            logic neg;
            w.distance = '0;
            w.degenerate = 1'b0;
            for (int i = 0; i < 3; i++) begin
                a[i] = c.first[i];
                b[i] = c.second[i];
                e[i] = longint'(c.second[i]) - c.first[i];
                f[i] = longint'(c.third[i]) - c.first[i];
            end
            if (c.action == pfpd_pkg::ACT_POINTS) begin
                r[0] = e[1] * f[2] - e[2] * f[1];
                r[1] = e[2] * f[0] - e[0] * f[2];
                r[2] = e[0] * f[1] - e[1] * f[0];
                if (r[0] == 0 && r[1] == 0 && r[2] == 0) w.degenerate = 1'b1;
                else fit_plane(r, a);
            end else if (c.action == pfpd_pkg::ACT_NORMAL) begin
                if (a[0] == 0 && a[1] == 0 && a[2] == 0) w.degenerate = 1'b1;
                else fit_plane(a, b);
            end else if (c.action == pfpd_pkg::ACT_QUERY) begin
                sum = 0;
                for (int i = 0; i < 3; i++)
                    sum += longint'(nrm[i] < 0 ? -nrm[i] : nrm[i]) *
                           longint'(nrm[i] < 0 ? -nrm[i] : nrm[i]);
                den = root64(sum);
                dot = nrm[0] * a[0] + nrm[1] * a[1] + nrm[2] * a[2];
                num = dot + ofs * (longint'(1) << pfpd_pkg::NORM_FRAC);
                neg = (num < 0) && c.signed_mode;
                if (den != 0) begin
                    q = ((num < 0 ? -num : num) + den / 2) / den;
                    if (q > (64'd1 << (pfpd_pkg::COORD_W - 1)))
                        q = 64'd1 << (pfpd_pkg::COORD_W - 1);
                    if (!neg && q > (64'd1 << (pfpd_pkg::COORD_W - 1)) - 1)
                        q = (64'd1 << (pfpd_pkg::COORD_W - 1)) - 1;
                    w.distance = pfpd_pkg::COORD_W'(neg ? -longint'(q) : longint'(q));
                end
            end
            w.nx = pfpd_pkg::NORMAL_W'(nrm[0]);
            w.ny = pfpd_pkg::NORMAL_W'(nrm[1]);
            w.nz = pfpd_pkg::NORMAL_W'(nrm[2]);
            w.offset = pfpd_pkg::OFFSET_W'(ofs);
            pending.push_back(w);
        endfunction

        function void check_word(t_plane_word got);
            t_plane_word exp_w;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result word");
                return;
            end
            exp_w = pending.pop_front();
            if (got !== exp_w) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp d=%0d n=%0d,%0d,%0d o=%0d g=%0b",
                              " | got d=%0d n=%0d,%0d,%0d o=%0d g=%0b"},
                             exp_w.distance, exp_w.nx, exp_w.ny, exp_w.nz, exp_w.offset,
                             exp_w.degenerate, got.distance, got.nx, got.ny, got.nz,
                             got.offset, got.degenerate);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    pfpd_in_if  cmd_ch ();
    pfpd_out_if res_ch ();

    plane_from_points_distance dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch.sink),
        .o_out   (res_ch.source)
    );

    plane_scoreboard sb;
    int  send_idle_pct;   // sender gap chance, percent
    int  stall_pct;       // receiver stall chance, percent
    int  hold_cycles;     // long receiver hold-off request
    bit  all_sent;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic signed [pfpd_pkg::COORD_W-1:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return 24'sh7fffff;
            1: return 24'sh800000;
            2: return 24'($urandom_range(0, 8)) - 24'sd4;
            3: return $signed(24'($urandom_range(0, 4095))) - 24'sd2048;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic t_plane_cmd rnd_cmd();
        t_plane_cmd c;
        c.action = 2'($urandom_range(0, 9) < 4 ? pfpd_pkg::ACT_QUERY : $urandom_range(0, 3));
        for (int i = 0; i < 3; i++) begin
            c.first[i]  = rnd_coord();
            c.second[i] = rnd_coord();
            c.third[i]  = rnd_coord();
        end
        // collinear or repeated points now and then
        if ($urandom_range(0, 9) == 0) c.third = c.first;
        if ($urandom_range(0, 19) == 0) c.first = '{0, 0, 0};
        c.signed_mode = 1'($urandom);
        return c;
    endfunction

    function automatic t_plane_cmd make_cmd(logic [1:0] act, int ax, int ay, int az,
                                            int bx, int by, int bz,
                                            int cx, int cy, int cz, logic sm);
        t_plane_cmd c;
        c.action = act;
        c.first  = '{24'(ax), 24'(ay), 24'(az)};
        c.second = '{24'(bx), 24'(by), 24'(bz)};
        c.third  = '{24'(cx), 24'(cy), 24'(cz)};
        c.signed_mode = sm;
        return c;
    endfunction

    // Offer one word, hold until accepted; valid stays up for a following word.
    task automatic send_word(t_plane_cmd c);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.action      <= c.action;
        cmd_ch.x_first     <= c.first[0];
        cmd_ch.y_first     <= c.first[1];
        cmd_ch.z_first     <= c.first[2];
        cmd_ch.x_second    <= c.second[0];
        cmd_ch.y_second    <= c.second[1];
        cmd_ch.z_second    <= c.second[2];
        cmd_ch.x_third     <= c.third[0];
        cmd_ch.y_third     <= c.third[1];
        cmd_ch.z_third     <= c.third[2];
        cmd_ch.signed_mode <= c.signed_mode;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_cmd(c);
    endtask

    task automatic drain_wait();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    initial begin
        t_plane_word w;
        res_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                w.distance   = res_ch.distance;
                w.nx         = res_ch.normal_x;
                w.ny         = res_ch.normal_y;
                w.nz         = res_ch.normal_z;
                w.offset     = res_ch.offset;
                w.degenerate = res_ch.degenerate;
                sb.check_word(w);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= !(stall_pct > 0 && $urandom_range(0, 99) < stall_pct);
            end
        end
    end

    initial begin
        t_plane_cmd c;
        int wait_cnt;
        sb = new();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        all_sent = 0;
        i_rst_n <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.action <= pfpd_pkg::ACT_QUERY;
        {cmd_ch.x_first, cmd_ch.y_first, cmd_ch.z_first} <= '0;
        {cmd_ch.x_second, cmd_ch.y_second, cmd_ch.z_second} <= '0;
        {cmd_ch.x_third, cmd_ch.y_third, cmd_ch.z_third} <= '0;
        cmd_ch.signed_mode <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset plane, extremes, degenerate builds, unused action.
        send_word(make_cmd(pfpd_pkg::ACT_QUERY, 0, 0, -65536, 0, 0, 0, 0, 0, 0, 1'b1));
        send_word(make_cmd(pfpd_pkg::ACT_QUERY, 0, 0, -65536, 0, 0, 0, 0, 0, 0, 1'b0));
        send_word(make_cmd(pfpd_pkg::ACT_QUERY, 0, 0, -8388608, 0, 0, 0, 0, 0, 0, 1'b1));
        send_word(make_cmd(pfpd_pkg::ACT_QUERY, 0, 0, 8388607, 0, 0, 0, 0, 0, 0, 1'b1));
        send_word(make_cmd(pfpd_pkg::ACT_POINTS, 5, 5, 5, 5, 5, 5, 9, 9, 9, 1'b0));
        send_word(make_cmd(pfpd_pkg::ACT_POINTS, 0, 0, 0, 65536, 65536, 65536,
                           -65536, -65536, -65536, 1'b0));
        send_word(make_cmd(pfpd_pkg::ACT_NORMAL, 0, 0, 0, 100, 200, 300, 0, 0, 0, 1'b0));
        send_word(make_cmd(pfpd_pkg::ACT_POINTS, 0, 0, 0, 65536, 0, 0, 0, 65536, 0, 1'b0));
        send_word(make_cmd(pfpd_pkg::ACT_POINTS, -8388608, -8388608, -8388608, 8388607,
                           -8388608, -8388608, -8388608, 8388607, 8388607, 1'b1));
        send_word(make_cmd(pfpd_pkg::ACT_QUERY, 8388607, 8388607, 8388607, 0, 0, 0,
                           0, 0, 0, 1'b1));
        send_word(make_cmd(pfpd_pkg::ACT_QUERY, -8388608, -8388608, -8388608, 0, 0, 0,
                           0, 0, 0, 1'b1));
        send_word(make_cmd(pfpd_pkg::ACT_NORMAL, 1, 0, 0, 8388607, 0, 0, 0, 0, 0, 1'b0));
        send_word(make_cmd(pfpd_pkg::ACT_QUERY, -8388608, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_word(make_cmd(pfpd_pkg::ACT_NORMAL, -8388608, -8388608, -8388608, -8388608,
                           -8388608, -8388608, 0, 0, 0, 1'b0));
        send_word(make_cmd(pfpd_pkg::ACT_QUERY, 8388607, 8388607, 8388607, 0, 0, 0,
                           0, 0, 0, 1'b1));
        send_word(make_cmd(pfpd_pkg::ACT_NORMAL, 0, 0, -1, 0, 0, 8388607, 0, 0, 0, 1'b0));
        send_word(make_cmd(pfpd_pkg::ACT_QUERY, 0, 0, -8388608, 0, 0, 0, 0, 0, 0, 1'b0));
        send_word(make_cmd(pfpd_pkg::ACT_UNUSED, 1, 2, 3, 4, 5, 6, 7, 8, 9, 1'b1));
        send_word(make_cmd(pfpd_pkg::ACT_NORMAL, 3, -4, 12, 65536, -65536, 32768,
                           0, 0, 0, 1'b1));
        send_word(make_cmd(pfpd_pkg::ACT_QUERY, 1, -1, 1, 0, 0, 0, 0, 0, 0, 1'b1));

        // Random phases: none, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 50 : (ph == 3) ? 18 : 0;
            stall_pct     = (ph == 2) ? 50 : (ph == 3) ? 18 : 0;
            if (ph == 2) hold_cycles = 1500;   // long back-pressure while sending
            for (int k = 0; k < 145; k++) begin
                c = rnd_cmd();
                send_word(c);
            end
            if (ph == 1) begin
                cmd_ch.valid <= 1'b0;
                drain_wait();                   // sender pauses until all arrived
            end
        end
        cmd_ch.valid <= 1'b0;
        all_sent = 1;

        wait_cnt = 0;
        while (sb.pending.size() != 0 && wait_cnt < 200000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (400) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
